// ----- rtl/ventilator_safety_alarm_monitor_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the ventilator safety alarm monitor
// Used by vsam_back, the only module that checks its own logic.
// ---------------------------------------------------------------------------
`ifndef VENTILATOR_SAFETY_ALARM_MONITOR_TOP_ASSERT_SVH
`define VENTILATOR_SAFETY_ALARM_MONITOR_TOP_ASSERT_SVH

// same-cycle implication
`define VSAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VSAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vsam_pkg.sv -----
// ---------------------------------------------------------------------------
// vsam_pkg
// Types and constants of the ventilator safety alarm monitor.
// ---------------------------------------------------------------------------
package vsam_pkg;

  localparam int unsigned TimeW       = 32;
  localparam int unsigned HighHoldMs  = 300;
  localparam int unsigned LowWinDefMs = 10000;
  localparam int unsigned MsPerMin    = 60000;
  localparam int unsigned WinBreaths  = 2;

  localparam int unsigned FlagW    = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BpmW     = 8;
  localparam int unsigned QuoW     = 16;
  localparam int unsigned DivCntW  = 5;
  localparam int unsigned WinW     = 17;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = 1;

  // alarm flag bit positions
  localparam int unsigned FlagMaxP = 0;
  localparam int unsigned FlagClog = 1;
  localparam int unsigned FlagMinP = 2;
  localparam int unsigned FlagDisc = 3;
  localparam int unsigned FlagSens = 4;
  localparam int unsigned FlagConf = 5;
  localparam int unsigned FlagBatt = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCtrl    = 3'd0,
    CfgMaxP    = 3'd1,
    CfgMinP    = 3'd2,
    CfgMinFlow = 3'd3,
    CfgDelta   = 3'd4,
    CfgBatt    = 3'd5,
    CfgBpm     = 3'd6,
    CfgMask    = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    ActSample = 1'b0,
    ActClear  = 1'b1
  } action_e;

  typedef struct packed {
    logic                    chk_en;
    logic                    cfg_bad;
    logic signed [15:0]      max_p;
    logic signed [15:0]      min_p;
    logic signed [15:0]      min_flow;
    logic        [15:0]      max_delta;
    logic        [15:0]      min_batt;
    logic        [WinW-1:0]  win;
    logic        [FlagW-1:0] mask;
  } cfg_t;

  // classified item, front to back
  typedef struct packed {
    logic             clear;
    logic [TimeW-1:0] now;
    logic             active;
    logic             started;
    logic             ge_max;
    logic             le_min;
    logic             clog;
    logic             sens;
    logic             batt_low;
  } cls_t;

endpackage

// ----- rtl/vsam_cfg.sv -----
// ---------------------------------------------------------------------------
// vsam_cfg
// Configuration registers and the breath window divider.
// ---------------------------------------------------------------------------
module vsam_cfg
  import vsam_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o,
  output logic                busy_o
);

  cfg_t               cfg_q;
  logic               div_busy_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [BpmW-1:0]    div_rem_q;
  logic [BpmW-1:0]    div_den_q;
  logic [QuoW-1:0]    div_num_q;

  logic [BpmW:0]      trial;
  logic               trial_ge;
  logic [BpmW:0]      trial_sub;
  logic [QuoW-1:0]    num_next;
  logic               wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  // one restoring step per cycle: 60000 / bpm
  assign trial     = {div_rem_q, div_num_q[QuoW-1]};
  assign trial_ge  = trial >= {1'b0, div_den_q};
  assign trial_sub = trial - {1'b0, div_den_q};
  assign num_next  = {div_num_q[QuoW-2:0], trial_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chk_en    <= 1'b1;
      cfg_q.cfg_bad   <= 1'b0;
      cfg_q.max_p     <= '0;
      cfg_q.min_p     <= '0;
      cfg_q.min_flow  <= '0;
      cfg_q.max_delta <= '0;
      cfg_q.min_batt  <= '0;
      cfg_q.win       <= WinW'(LowWinDefMs);
      cfg_q.mask      <= '1;
      div_busy_q      <= 1'b0;
      div_cnt_q       <= '0;
    end else begin
      if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == DivCntW'(1)) begin
          div_busy_q <= 1'b0;
          cfg_q.win  <= WinW'(num_next * WinBreaths);
        end
      end
      if (wr) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgCtrl:    begin
            cfg_q.chk_en  <= cfg_data_i[0];
            cfg_q.cfg_bad <= cfg_data_i[1];
          end
          CfgMaxP:    cfg_q.max_p     <= cfg_data_i;
          CfgMinP:    cfg_q.min_p     <= cfg_data_i;
          CfgMinFlow: cfg_q.min_flow  <= cfg_data_i;
          CfgDelta:   cfg_q.max_delta <= cfg_data_i;
          CfgBatt:    cfg_q.min_batt  <= cfg_data_i;
          CfgBpm:     begin
            if (cfg_data_i[BpmW-1:0] == '0) begin
              div_busy_q <= 1'b0;
              cfg_q.win  <= WinW'(LowWinDefMs);
            end else begin
              div_busy_q <= 1'b1;
              div_cnt_q  <= DivCntW'(QuoW);
            end
          end
          CfgMask:    cfg_q.mask      <= cfg_data_i[FlagW-1:0];
          default:    ;
        endcase
      end
    end
  end

  // divider datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (wr && cfg_idx_e'(cfg_index_i) == CfgBpm) begin
      div_den_q <= cfg_data_i[BpmW-1:0];
      div_rem_q <= '0;
      div_num_q <= QuoW'(MsPerMin);
    end else if (div_busy_q) begin
      div_rem_q <= trial_ge ? trial_sub[BpmW-1:0] : trial[BpmW-1:0];
      div_num_q <= num_next;
    end
  end

  assign cfg_o  = cfg_q;
  assign busy_o = div_busy_q;

endmodule

// ----- rtl/vsam_front.sv -----
// ---------------------------------------------------------------------------
// vsam_front
// Accepts sample beats and classifies them against the limits.
// ---------------------------------------------------------------------------
module vsam_front
  import vsam_pkg::*;
(
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic               process_active_i,
  input  logic               run_started_i,
  input  logic signed [15:0] pressure_main_i,
  input  logic signed [15:0] pressure_redundant_i,
  input  logic signed [15:0] flow_pressure_i,
  input  logic [15:0]        battery_level_i,
  input  cfg_t               cfg_i,
  input  logic               busy_i,
  input  logic               full_i,
  output logic               push_o,
  output cls_t               cls_o
);

  logic signed [16:0] diff;
  logic        [16:0] adiff;

  // queue full or window divider running: hold input off
  assign in_ready_o = !full_i && !busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign diff  = {pressure_main_i[15], pressure_main_i}
               - {pressure_redundant_i[15], pressure_redundant_i};
  assign adiff = diff[16] ? 17'(-diff) : 17'(diff);

  always_comb begin
    cls_o.clear    = action_e'(action_i) == ActClear;
    cls_o.now      = now_ms_i;
    cls_o.active   = process_active_i;
    cls_o.started  = run_started_i;
    cls_o.ge_max   = pressure_main_i >= cfg_i.max_p;
    cls_o.le_min   = pressure_main_i <= cfg_i.min_p;
    cls_o.clog     = flow_pressure_i <= cfg_i.min_flow;
    cls_o.sens     = adiff >= {1'b0, cfg_i.max_delta};
    cls_o.batt_low = battery_level_i < cfg_i.min_batt;
  end

endmodule

// ----- rtl/vsam_fifo.sv -----
// ---------------------------------------------------------------------------
// vsam_fifo
// Two-entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
module vsam_fifo
  import vsam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cls_t data_o
);

  cls_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoPtrW:0]   cnt_q;

  assign full_o  = cnt_q == (FifoPtrW+1)'(FifoDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ----- rtl/vsam_back.sv -----
// ---------------------------------------------------------------------------
// vsam_back
// Timer and alarm state update, result register.
// ---------------------------------------------------------------------------
`include "ventilator_safety_alarm_monitor_top_assert.svh"

module vsam_back
  import vsam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             fifo_valid_i,
  input  cls_t             fifo_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [FlagW-1:0] alarm_flags_o,
  output logic             critical_o,
  output logic             enter_error_o
);

  logic [TimeW-1:0] tmax_q, tmax_d;
  logic [TimeW-1:0] tmin_q, tmin_d;
  logic [FlagW-1:0] alarm_q, alarm_d;
  logic             crit_q, crit_d;
  logic             ee_d;

  logic             out_valid_q;
  logic [FlagW-1:0] out_flags_q;
  logic             out_crit_q;
  logic             out_ee_q;

  cls_t             it;
  logic             pop;
  logic [TimeW-1:0] el_max, el_min;
  logic             max_late, min_late;
  logic [FlagW-1:0] flags;

  assign it  = fifo_data_i;
  assign pop = fifo_valid_i && (!out_valid_q || out_ready_i);

  assign el_max   = it.now - tmax_q;
  assign el_min   = it.now - tmin_q;
  assign max_late = it.started && (el_max > TimeW'(HighHoldMs));
  assign min_late = it.started && (el_min > TimeW'(cfg_i.win));

  always_comb begin
    flags = alarm_q & ~cfg_i.mask;
    if (it.ge_max && max_late) begin
      flags[FlagMaxP] = 1'b1;
      if (it.clog) flags[FlagClog] = 1'b1;
    end
    if (it.le_min && min_late) begin
      flags[FlagMinP] = 1'b1;
      flags[FlagDisc] = 1'b1;
    end
    if (it.sens)      flags[FlagSens] = 1'b1;
    if (cfg_i.cfg_bad) flags[FlagConf] = 1'b1;
    if (it.batt_low)  flags[FlagBatt] = 1'b1;
  end

  always_comb begin
    tmax_d  = tmax_q;
    tmin_d  = tmin_q;
    alarm_d = alarm_q;
    crit_d  = crit_q;
    ee_d    = 1'b0;
    if (it.clear) begin
      alarm_d = '0;
      crit_d  = 1'b0;
    end else if (!it.active) begin
      tmax_d = it.now;
      tmin_d = it.now;
    end else begin
      // run not started, or pressure back inside its limit with checks on, restarts the hold timer
      if (!it.started || (cfg_i.chk_en && !it.ge_max)) tmax_d = it.now;
      if (!it.started || (cfg_i.chk_en && !it.le_min)) tmin_d = it.now;
      if (cfg_i.chk_en) begin
        alarm_d = flags;
        if ((flags & cfg_i.mask) != '0) begin
          crit_d = 1'b1;
          ee_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmax_q      <= '0;
      tmin_q      <= '0;
      alarm_q     <= '0;
      crit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        tmax_q      <= tmax_d;
        tmin_q      <= tmin_d;
        alarm_q     <= alarm_d;
        crit_q      <= crit_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_flags_q <= alarm_d;
      out_crit_q  <= crit_d;
      out_ee_q    <= ee_d;
    end
  end

  assign pop_o         = pop;
  assign out_valid_o   = out_valid_q;
  assign alarm_flags_o = out_flags_q;
  assign critical_o    = out_crit_q;
  assign enter_error_o = out_ee_q;

  `VSAM_ASSERT_IMP(a_err_implies_crit, out_valid_q && out_ee_q, out_crit_q,
    "error request without critical latch")
  `VSAM_ASSERT_NXT(a_clear_empties, pop && it.clear,
    out_flags_q == '0 && !out_crit_q && !out_ee_q, "clear beat left alarms set")
  `VSAM_ASSERT_NXT(a_idle_syncs_timers, pop && !it.clear && !it.active,
    tmax_q == tmin_q, "inactive sample did not sync both timers")

endmodule

// ----- rtl/ventilator_safety_alarm_monitor_top.sv -----
// ---------------------------------------------------------------------------
// ventilator_safety_alarm_monitor_top
// Per-sample airway pressure, sensor, config and battery alarm monitor.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one beat per sample or clear
//    command. Output channel (out_valid_o/out_ready_i): exactly one result
//    beat per input beat, in order: alarm flags, critical latch, error req.
//  - Config channel (cfg_valid_i/cfg_ready_o): register index + data, always
//    ready; write only while no beat is in flight.
//  - Flow: an input beat is written into the two-entry queue; the back
//    stage pops it and out_valid_o rises once the result register is free.
//    Throughput: one beat per cycle unless the divider runs or the output
//    stalls, set by the back-stage state update (timer subtracts and compares).
//  - Writing a nonzero breaths_per_minute starts a bit-serial divide of 60000 by
//    the rate; in_ready_o stays low until the divide is done.
//  - Reset: timers, alarm register and latch cleared, config at defaults,
//    in_ready_o high right after reset.
//  - Receiver stall: the result register holds; the two-entry queue fills
//    and then in_ready_o drops until the output drains.
// ---------------------------------------------------------------------------
module ventilator_safety_alarm_monitor_top
  import vsam_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // samples in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic                process_active_i,
  input  logic                run_started_i,
  input  logic signed [15:0]  pressure_main_i,
  input  logic signed [15:0]  pressure_redundant_i,
  input  logic signed [15:0]  flow_pressure_i,
  input  logic [15:0]         battery_level_i,
  // results out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FlagW-1:0]    alarm_flags_o,
  output logic                critical_o,
  output logic                enter_error_o
);

  cfg_t cfg;
  logic div_busy;
  logic q_full, q_valid, q_push, q_pop;
  cls_t q_wdata, q_rdata;

  // config registers plus breath window divider
  vsam_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .busy_o      (div_busy)
  );

  // front: limit compares, no state
  vsam_front u_front (
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .now_ms_i             (now_ms_i),
    .process_active_i     (process_active_i),
    .run_started_i        (run_started_i),
    .pressure_main_i      (pressure_main_i),
    .pressure_redundant_i (pressure_redundant_i),
    .flow_pressure_i      (flow_pressure_i),
    .battery_level_i      (battery_level_i),
    .cfg_i                (cfg),
    .busy_i               (div_busy),
    .full_i               (q_full),
    .push_o               (q_push),
    .cls_o                (q_wdata)
  );

  vsam_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  // back: timers, alarm register, critical latch, result register
  vsam_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .fifo_valid_i  (q_valid),
    .fifo_data_i   (q_rdata),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .alarm_flags_o (alarm_flags_o),
    .critical_o    (critical_o),
    .enter_error_o (enter_error_o)
  );

endmodule

// ----- verif/tb_ventilator_safety_alarm_monitor_top.sv -----
// ---------------------------------------------------------------------------
// tb_ventilator_safety_alarm_monitor_top
// Self-checking bench for the alarm monitor: a directed table, then random
// breath-like sample streams under several register settings, each result
// beat checked against the table's expected value or an in-bench model.
// ---------------------------------------------------------------------------
module tb_ventilator_safety_alarm_monitor_top;
  import vsam_pkg::*;

  localparam int unsigned StallLimit = 2000;  // cycles with no beat at all
  localparam int unsigned HoldCycles = 300;   // long receiver back-pressure
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 110;

  typedef struct {
    action_e            action;
    logic [TimeW-1:0]   now;
    logic               active;
    logic               started;
    logic signed [15:0] p_main;
    logic signed [15:0] p_red;
    logic signed [15:0] p_flow;
    logic [15:0]        batt;
  } sample_t;

  typedef struct {
    logic [FlagW-1:0] flags;
    logic             crit;
    logic             err;
  } alarm_result_t;

  typedef struct {
    cfg_idx_e    idx;
    logic [15:0] data;
  } reg_write_t;

  // one line of the directed table: a register write or a sample beat
  typedef struct {
    bit            is_cfg;
    reg_write_t    w;
    sample_t       s;
    bit            typed;
    alarm_result_t want;
  } row_t;

  // DUT hookup, every input known from time zero
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                action_i = 1'b0;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic                process_active_i = 1'b0;
  logic                run_started_i = 1'b0;
  logic signed [15:0]  pressure_main_i = '0;
  logic signed [15:0]  pressure_redundant_i = '0;
  logic signed [15:0]  flow_pressure_i = '0;
  logic [15:0]         battery_level_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [FlagW-1:0]    alarm_flags_o;
  logic                critical_o;
  logic                enter_error_o;

  ventilator_safety_alarm_monitor_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .now_ms_i             (now_ms_i),
    .process_active_i     (process_active_i),
    .run_started_i        (run_started_i),
    .pressure_main_i      (pressure_main_i),
    .pressure_redundant_i (pressure_redundant_i),
    .flow_pressure_i      (flow_pressure_i),
    .battery_level_i      (battery_level_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .alarm_flags_o        (alarm_flags_o),
    .critical_o           (critical_o),
    .enter_error_o        (enter_error_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Alarm model state: timers, alarm register, latch, and register shadow
  // -------------------------------------------------------------------------
  logic [TimeW-1:0]   ok_hi_ms, ok_lo_ms;   // last time pressure was in range
  logic [FlagW-1:0]   alarm_reg;
  logic               crit_latch;
  logic               chk_en, cfg_bad;
  logic signed [15:0] lim_max, lim_min, lim_flow;
  logic [15:0]        lim_delta, lim_batt;
  logic [BpmW-1:0]    bpm;
  logic [FlagW-1:0]   crit_mask;

  alarm_result_t expected_alarms_q[$];
  int            mismatches = 0;

  // stimulus shaping
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  logic             hold_req = 1'b0;
  int unsigned      hold_left = 0;
  logic [TimeW-1:0] clock_ms = '0;
  int unsigned      regime = 2;
  int unsigned      quiet_cycles = 0;

  initial begin
    ok_hi_ms   = '0;
    ok_lo_ms   = '0;
    alarm_reg  = '0;
    crit_latch = 1'b0;
    chk_en     = 1'b1;
    cfg_bad    = 1'b0;
    lim_max    = '0;
    lim_min    = '0;
    lim_flow   = '0;
    lim_delta  = '0;
    lim_batt   = '0;
    bpm        = '0;
    crit_mask  = '1;
  end

  // Steps the model by one beat and returns the result it must produce.
  function automatic alarm_result_t predict_alarm_result(input sample_t s);
    alarm_result_t    r;
    logic [FlagW-1:0] f;
    logic [TimeW-1:0] dt;
    int               adiff;
    int unsigned      win;
    r.err = 1'b0;
    if (s.action == ActClear) begin
      alarm_reg  = '0;
      crit_latch = 1'b0;
    end else if (!s.active) begin
      ok_hi_ms = s.now;
      ok_lo_ms = s.now;
    end else begin
      if (!s.started) begin
        ok_hi_ms = s.now;
        ok_lo_ms = s.now;
      end
      if (chk_en) begin
        // critical bits are re-evaluated on every enabled sample
        f = alarm_reg & ~crit_mask;
        adiff = int'(s.p_main) - int'(s.p_red);
        if (adiff < 0) adiff = -adiff;
        if (s.p_main >= lim_max) begin
          dt = s.now - ok_hi_ms;
          if (s.started && dt > HighHoldMs) begin
            f[FlagMaxP] = 1'b1;
            if (s.p_flow <= lim_flow) f[FlagClog] = 1'b1;
          end
        end else begin
          ok_hi_ms = s.now;
        end
        if (s.p_main <= lim_min) begin
          win = (bpm == 0) ? LowWinDefMs : (MsPerMin / bpm) * WinBreaths;
          dt = s.now - ok_lo_ms;
          if (s.started && dt > win) begin
            f[FlagMinP] = 1'b1;
            f[FlagDisc] = 1'b1;
          end
        end else begin
          ok_lo_ms = s.now;
        end
        if (adiff >= int'(lim_delta)) f[FlagSens] = 1'b1;
        if (cfg_bad) f[FlagConf] = 1'b1;
        if (s.batt < lim_batt) f[FlagBatt] = 1'b1;
        alarm_reg = f;
        if ((f & crit_mask) != '0) begin
          crit_latch = 1'b1;
          r.err      = 1'b1;
        end
      end
    end
    r.flags = alarm_reg;
    r.crit  = crit_latch;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Random helpers
  // -------------------------------------------------------------------------
  function automatic int pick(int lo, int hi);
    int t;
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Breath-like stream: time mostly creeps forward, pressure sits in a
  // regime (high / low / in band / anywhere) for a while so the hold timers
  // actually expire; other fields cluster around their thresholds.
  function automatic sample_t next_breath_sample();
    sample_t     s;
    int unsigned r;
    int          lo, hi, pm;
    r = $urandom_range(99);
    if (r < 70)      clock_ms += $urandom_range(40);
    else if (r < 88) clock_ms += $urandom_range(600, 41);
    else if (r < 97) clock_ms += $urandom_range(15000, 601);
    else             clock_ms += $urandom;   // big jump, may cross the wrap
    if ($urandom_range(23) == 0) regime = $urandom_range(3);
    lo = int'(lim_min);
    hi = int'(lim_max);
    case (regime)
      0:       pm = pick(hi, 32767);
      1:       pm = pick(-32768, lo);
      2:       pm = pick(lo, hi);
      default: pm = pick(-32768, 32767);
    endcase
    if ($urandom_range(9) == 0)
      pm = clip(($urandom_range(1) ? hi : lo) + pick(-2, 2), -32768, 32767);
    s.action  = ($urandom_range(99) < 4) ? ActClear : ActSample;
    s.now     = clock_ms;
    s.active  = ($urandom_range(99) >= 5);
    s.started = ($urandom_range(99) >= 7);
    s.p_main  = 16'(pm);
    s.p_red   = $urandom_range(1)
              ? 16'(clip(pm + pick(-int'(lim_delta) - 2, int'(lim_delta) + 2),
                         -32768, 32767))
              : 16'(pick(-32768, 32767));
    s.p_flow  = $urandom_range(1)
              ? 16'(clip(int'(lim_flow) + pick(-3, 3), -32768, 32767))
              : 16'(pick(-32768, 32767));
    s.batt    = $urandom_range(1)
              ? 16'(clip(int'(lim_batt) + pick(-3, 3), 0, 65535))
              : 16'($urandom_range(65535));
    return s;
  endfunction

  // -------------------------------------------------------------------------
  // Directed table builders
  // -------------------------------------------------------------------------
  function automatic row_t smp(action_e a, logic [TimeW-1:0] now, bit act, bit st,
                               int pm, int pr, int pf, int bat);
    row_t r;
    r.is_cfg    = 1'b0;
    r.typed     = 1'b0;
    r.s.action  = a;
    r.s.now     = now;
    r.s.active  = act;
    r.s.started = st;
    r.s.p_main  = 16'(pm);
    r.s.p_red   = 16'(pr);
    r.s.p_flow  = 16'(pf);
    r.s.batt    = 16'(bat);
    return r;
  endfunction

  function automatic row_t wr(cfg_idx_e i, int d);
    row_t r;
    r.is_cfg = 1'b1;
    r.typed  = 1'b0;
    r.w.idx  = i;
    r.w.data = 16'(d);
    return r;
  endfunction

  function automatic row_t chk(row_t r, int f, bit c, bit e);
    r.typed      = 1'b1;
    r.want.flags = FlagW'(f);
    r.want.crit  = c;
    r.want.err   = e;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Sender side. Tasks are entered right after a rising edge and return at
  // one, so each step carries at most one update per signal.
  // -------------------------------------------------------------------------
  task automatic push_item(input sample_t s, input bit typed, input alarm_result_t want);
    alarm_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    action_i             <= s.action;
    now_ms_i             <= s.now;
    process_active_i     <= s.active;
    run_started_i        <= s.started;
    pressure_main_i      <= s.p_main;
    pressure_redundant_i <= s.p_red;
    flow_pressure_i      <= s.p_flow;
    battery_level_i      <= s.batt;
    do @(posedge clk_i); while (!in_ready_o);
    // beat taken at this edge
    got = predict_alarm_result(s);
    expected_alarms_q.push_back(typed ? want : got);
  endtask

  // stop offering and wait until every result beat has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_alarms_q.size() != 0);
  endtask

  // register writes only with nothing in flight
  task automatic apply_cfg(input reg_write_t batch[$]);
    drain_results();
    foreach (batch[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= batch[i].idx;
      cfg_data_i  <= batch[i].data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (batch[i].idx)
        CfgCtrl: begin
          chk_en  = batch[i].data[0];
          cfg_bad = batch[i].data[1];
        end
        CfgMaxP:    lim_max   = batch[i].data;
        CfgMinP:    lim_min   = batch[i].data;
        CfgMinFlow: lim_flow  = batch[i].data;
        CfgDelta:   lim_delta = batch[i].data;
        CfgBatt:    lim_batt  = batch[i].data;
        CfgBpm:     bpm       = batch[i].data[BpmW-1:0];
        CfgMask:    crit_mask = batch[i].data[FlagW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Receiver side: checks each result beat, drives random back-pressure and
  // the long hold-off when asked for one.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : rx_side
    alarm_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_alarms_q.size() == 0) begin
        $error("result beat with no sample pending: flags %h", alarm_flags_o);
        mismatches++;
      end else begin
        want = expected_alarms_q.pop_front();
        if (alarm_flags_o !== want.flags) begin
          $error("alarm_flags: expected %h, got %h", want.flags, alarm_flags_o);
          mismatches++;
        end
        if (critical_o !== want.crit) begin
          $error("critical: expected %b, got %b", want.crit, critical_o);
          mismatches++;
        end
        if (enter_error_o !== want.err) begin
          $error("enter_error: expected %b, got %b", want.err, enter_error_o);
          mismatches++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: too long without any beat on any channel means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("** ventilator_safety_alarm_monitor_top: FAILED **");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    row_t          rows[$];
    reg_write_t    batch[$];
    alarm_result_t none;
    int            ctl, lo, hi;

    none = '{flags: '0, crit: 1'b0, err: 1'b0};

    // Directed: reset defaults first (checks on, limits zero, mask all),
    // then invalid config, battery threshold, disabled checks, rate window.
    rows = '{
      // zero delta always flags sensor mismatch, which is critical
      chk(smp(ActSample, 0, 1, 0, 0, 0, 0, 0), 1 << FlagSens, 1, 1),
      // clear with every field at an extreme
      chk(smp(ActClear, 32'hFFFF_FFFF, 1, 1, 32767, -32768, 32767, 65535), 0, 0, 0),
      // inactive: timers restart, alarms untouched
      chk(smp(ActSample, 32'hFFFF_FFFF, 0, 1, 32767, -32768, -32768, 65535), 0, 0, 0),
      // high pressure hold across the timestamp wrap, one ms either side
      smp(ActSample, 0, 1, 1, 32767, 32767, -32768, 0),
      smp(ActSample, 299, 1, 1, 32767, 32767, -32768, 0),
      smp(ActSample, 300, 1, 1, 32767, 32767, -32768, 0),
      // low pressure against the 10 s window
      smp(ActSample, 10300, 1, 1, -32768, -32768, 32767, 0),
      smp(ActSample, 10302, 1, 1, -32768, -32768, 32767, 0),
      // run not started: no pressure alarm possible
      smp(ActSample, 10303, 1, 0, -32768, -32768, 32767, 0),
      chk(smp(ActClear, 10304, 1, 1, 0, 0, 0, 0), 0, 0, 0),
      wr(CfgCtrl, 3),
      wr(CfgBatt, 65535),
      wr(CfgDelta, 65535),
      wr(CfgMask, 0),
      // widest sensor split, lowest battery, nothing critical
      smp(ActSample, 20000, 1, 1, -32768, 32767, 0, 65534),
      smp(ActSample, 20001, 1, 1, 0, 1, 0, 65535),
      wr(CfgCtrl, 2),
      // checks disabled
      smp(ActSample, 20002, 1, 1, 32767, -32768, -32768, 0),
      wr(CfgBpm, 255),
      wr(CfgMaxP, -32768),
      wr(CfgMinP, 32767),
      wr(CfgMinFlow, 32767),
      wr(CfgCtrl, 1),
      wr(CfgMask, 127),
      smp(ActSample, 30000, 1, 1, 0, 0, 0, 0),
      smp(ActSample, 30470, 1, 1, -32768, 0, 32767, 0),
      smp(ActSample, 30471, 1, 1, -32768, 0, -32768, 0),
      wr(CfgBpm, 1),
      smp(ActSample, 150471, 1, 1, 32767, 32767, 0, 100),
      smp(ActSample, 150472, 1, 1, 32767, -32768, 0, 100),
      chk(smp(ActClear, 150473, 0, 0, 0, 0, 0, 0), 0, 0, 0)
    };

    send_idle_pct = 27;
    recv_idle_pct = 79;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        batch.push_back(rows[i].w);
      end else begin
        if (batch.size() != 0) begin
          apply_cfg(batch);
          batch.delete();
        end
        push_item(rows[i].s, rows[i].typed, rows[i].want);
      end
    end

    clock_ms = 32'd200000;
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0) begin
        // every register at its top value
        batch = '{'{CfgCtrl, 16'd3}, '{CfgMaxP, 16'h7FFF}, '{CfgMinP, 16'h7FFF},
                  '{CfgMinFlow, 16'h7FFF}, '{CfgDelta, 16'hFFFF},
                  '{CfgBatt, 16'hFFFF}, '{CfgBpm, 16'd255}, '{CfgMask, 16'd127}};
      end else if (ph == 1) begin
        // and at its bottom value, checks kept on
        batch = '{'{CfgCtrl, 16'd1}, '{CfgMaxP, 16'h8000}, '{CfgMinP, 16'h8000},
                  '{CfgMinFlow, 16'h8000}, '{CfgDelta, 16'd0}, '{CfgBatt, 16'd0},
                  '{CfgBpm, 16'd1}, '{CfgMask, 16'd0}};
      end else begin
        ctl = ($urandom_range(3) != 0) ? 1 : int'($urandom_range(3));
        if ($urandom_range(3) == 0) begin
          lo = pick(-32768, 32767);
          hi = pick(-32768, 32767);
        end else begin
          lo = pick(-2000, 500);
          hi = pick(lo, 4000);
        end
        batch = '{'{CfgCtrl, 16'(ctl)}, '{CfgMaxP, 16'(hi)}, '{CfgMinP, 16'(lo)},
                  '{CfgMinFlow, 16'(pick(-1000, 1000))},
                  '{CfgDelta, 16'($urandom_range(1) ? $urandom_range(300)
                                                    : $urandom_range(65535))},
                  '{CfgBatt, 16'($urandom_range(65535))},
                  '{CfgBpm, 16'(($urandom_range(3) == 0) ? 0 : $urandom_range(255, 1))},
                  '{CfgMask, 16'($urandom_range(127))}};
      end
      send_idle_pct = (ph < 4) ? 27 : (ph < 7) ? 79 : 0;
      recv_idle_pct = (ph < 4) ? 79 : (ph < 7) ? 27 : 0;
      apply_cfg(batch);
      for (int k = 0; k < PhaseItems; k++) begin
        // receiver stalls for a long stretch while beats keep coming
        if (k == 50 && (ph == 2 || ph == 8)) hold_req = 1'b1;
        // sender stops until the pipe is empty, then resumes
        if (k == 55 && ph == 5) drain_results();
        push_item(next_breath_sample(), 1'b0, none);
      end
    end

    drain_results();
    // keep clocking to catch any stray result beat
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** ventilator_safety_alarm_monitor_top: PASSED **");
    end else begin
      $display("** ventilator_safety_alarm_monitor_top: FAILED **");
    end
    $finish;
  end

endmodule
